// ===== rtl/assert_macros.svh =====
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent on an edge requires the consequent on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/acc_pkg.sv =====
package acc_pkg;

	typedef struct packed {
		logic       func;
		logic [4:0] key_code;
	} item_t;

	typedef struct packed {
		logic [4:0] shown_hour;
		logic [5:0] shown_minute;
		logic       hour_visible;
		logic       minute_visible;
		logic       led_lit;
		logic       buzzer_drive;
		logic [2:0] mode;
		logic       store_alarm;
		logic [4:0] alarm_hour_value;
		logic [5:0] alarm_minute_value;
	} result_t;

	// item kinds
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_KEY  = 1'b1;

	// key codes
	localparam logic [4:0] KEY_SET  = 5'd3;
	localparam logic [4:0] KEY_UP   = 5'd6;
	localparam logic [4:0] KEY_DOWN = 5'd10;
	localparam logic [4:0] KEY_ALM  = 5'd16;

	// register indexes
	localparam logic [2:0] REG_TICKS_PER_SECOND  = 3'd0;
	localparam logic [2:0] REG_BLINK_HALF_PERIOD = 3'd1;
	localparam logic [2:0] REG_IDLE_TIMEOUT      = 3'd2;
	localparam logic [2:0] REG_PIP_LENGTH        = 3'd3;
	localparam logic [2:0] REG_ALARM_HALF_PERIOD = 3'd4;
	localparam logic [2:0] REG_ALARM_DURATION    = 3'd5;

	// register reset values
	localparam logic [15:0] RST_TICKS_PER_SECOND  = 16'd1000;
	localparam logic [15:0] RST_BLINK_HALF_PERIOD = 16'd500;
	localparam logic [15:0] RST_IDLE_TIMEOUT      = 16'd30000;
	localparam logic [15:0] RST_PIP_LENGTH        = 16'd300;
	localparam logic [15:0] RST_ALARM_HALF_PERIOD = 16'd500;
	localparam logic [15:0] RST_ALARM_DURATION    = 16'd5000;

	// time limits
	localparam logic [5:0] HOUR_MAX   = 6'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [6:0] SEC_WRAP   = 7'd60;
	localparam logic [6:0] MIN_WRAP   = 7'd60;
	localparam logic [5:0] HOUR_WRAP  = 6'd24;

endpackage

// ===== rtl/alarm_clock_controller_top.sv =====
// Channel  Handshake              Payload
// item     item_valid/item_stall  acc_pkg::item_t   (tick or key press)
// result   result_valid/result_stall acc_pkg::result_t (display, buzzer, mode)
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data (16-bit registers)
//
// One item per cycle sustained while the result is not stalled; an accepted item
// passes from the input register through the state update into the result register.
// arst_n clears the clock, alarm, counters and registers to their defaults.
// A stalled result holds the result register; item_stall rises only when the
// input register holds an item and the result register holds a stalled result.
// cfg_ready is always high; writes to indexes above five are dropped.
module alarm_clock_controller_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  acc_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output acc_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_SET_HOUR,
		MODE_SET_MINUTE,
		MODE_ALARM_HOUR,
		MODE_ALARM_MINUTE
	} mode_t;

	// configuration registers
	logic [15:0] ticks_per_second_q, blink_half_period_q, idle_timeout_q;
	logic [15:0] pip_length_q, alarm_half_period_q, alarm_duration_q;

	// clock state
	mode_t       mode_q, mode_n;
	logic [4:0]  hours_q, hours_n, alarm_hours_q, alarm_hours_n;
	logic [5:0]  minutes_q, minutes_n, seconds_q, seconds_n;
	logic [5:0]  alarm_minutes_q, alarm_minutes_n;
	logic [15:0] millis_q, millis_n, blink_cnt_q, blink_cnt_n, idle_cnt_q, idle_cnt_n;
	logic        blink_phase_q, blink_phase_n;
	logic [15:0] pip_left_q, pip_left_n;
	logic        alarm_on_q, alarm_on_n;
	logic [15:0] alarm_left_q, alarm_left_n, phase_left_q, phase_left_n;
	logic        phase_snd_q, phase_snd_n, buzzer_q, buzzer_n;
	logic        store_n;

	// pipeline
	logic             valid_s1;
	acc_pkg::item_t   item_s1;
	logic             result_valid_q;
	acc_pkg::result_t result_q, result_n;
	logic             out_free, advance;

	assign out_free     = !result_valid_q || !result_stall;
	assign advance      = valid_s1 && out_free;
	assign item_stall   = valid_s1 && !out_free;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	function automatic logic [5:0] step_value(logic [5:0] v, logic [4:0] key, logic [5:0] top);
		logic [5:0] r;
		r = v;
		if (key == acc_pkg::KEY_UP)
			r = (v >= top) ? 6'd0 : v + 6'd1;
		else if (key == acc_pkg::KEY_DOWN)
			r = (v == 6'd0 || v > top) ? top : v - 6'd1;
		return r;
	endfunction

	always_comb begin
		logic [6:0]  sec_inc, min_inc;
		logic [5:0]  hour_inc;
		logic [15:0] millis_inc, blink_inc, idle_inc, phase_dec;
		logic        alarm_view, hidden;

		mode_n          = mode_q;
		hours_n         = hours_q;
		minutes_n       = minutes_q;
		seconds_n       = seconds_q;
		alarm_hours_n   = alarm_hours_q;
		alarm_minutes_n = alarm_minutes_q;
		millis_n        = millis_q;
		blink_cnt_n     = blink_cnt_q;
		idle_cnt_n      = idle_cnt_q;
		blink_phase_n   = blink_phase_q;
		pip_left_n      = pip_left_q;
		alarm_on_n      = alarm_on_q;
		alarm_left_n    = alarm_left_q;
		phase_left_n    = phase_left_q;
		phase_snd_n     = phase_snd_q;
		buzzer_n        = buzzer_q;
		store_n         = 1'b0;
		sec_inc         = {1'b0, seconds_q} + 7'd1;
		min_inc         = {1'b0, minutes_q} + 7'd1;
		hour_inc        = {1'b0, hours_q} + 6'd1;
		millis_inc      = millis_q + 16'd1;
		blink_inc       = blink_cnt_q + 16'd1;
		idle_inc        = idle_cnt_q + 16'd1;
		phase_dec       = 16'd0;

		if (item_s1.func == acc_pkg::FUNC_TICK) begin
			millis_n = millis_inc;
			if (millis_inc >= ticks_per_second_q) begin
				millis_n = 16'd0;
				if (mode_q == MODE_NORMAL) begin
					seconds_n = sec_inc[5:0];
					if (sec_inc >= acc_pkg::SEC_WRAP) begin
						seconds_n = 6'd0;
						minutes_n = min_inc[5:0];
						if (min_inc >= acc_pkg::MIN_WRAP) begin
							minutes_n = 6'd0;
							hours_n   = hour_inc[4:0];
							if (hour_inc >= acc_pkg::HOUR_WRAP)
								hours_n = 5'd0;
						end
						if (hours_n == alarm_hours_q && minutes_n == alarm_minutes_q) begin
							pip_left_n   = 16'd0;
							alarm_on_n   = 1'b1;
							alarm_left_n = alarm_duration_q;
							phase_left_n = alarm_half_period_q;
							phase_snd_n  = 1'b1;
							buzzer_n     = 1'b1;
						end
					end
				end
			end
			if (mode_q != MODE_NORMAL) begin
				blink_cnt_n = blink_inc;
				if (blink_inc >= blink_half_period_q) begin
					blink_cnt_n   = 16'd0;
					blink_phase_n = !blink_phase_q;
				end
				idle_cnt_n = idle_inc;
				if (idle_inc >= idle_timeout_q) begin
					idle_cnt_n    = 16'd0;
					mode_n        = MODE_NORMAL;
					blink_phase_n = 1'b1;
					if (!alarm_on_n) begin
						pip_left_n = pip_length_q;
						buzzer_n   = 1'b1;
					end
				end
			end else begin
				blink_phase_n = 1'b1;
			end
			// buzzer sequencing runs on the already updated alarm/pip state
			if (alarm_on_n) begin
				if (alarm_left_n != 16'd0) begin
					alarm_left_n = alarm_left_n - 16'd1;
					phase_dec    = phase_left_n - 16'd1;
					phase_left_n = phase_dec;
					if (phase_dec == 16'd0) begin
						phase_left_n = alarm_half_period_q;
						phase_snd_n  = !phase_snd_n;
						buzzer_n     = phase_snd_n;
					end
				end else begin
					alarm_on_n = 1'b0;
					buzzer_n   = 1'b0;
				end
			end else if (pip_left_n != 16'd0) begin
				pip_left_n = pip_left_n - 16'd1;
				if (pip_left_n == 16'd0)
					buzzer_n = 1'b0;
			end
		end else begin
			if (!alarm_on_q) begin
				pip_left_n = pip_length_q;
				buzzer_n   = 1'b1;
			end
			idle_cnt_n    = 16'd0;
			blink_cnt_n   = 16'd0;
			blink_phase_n = 1'b1;
			case (mode_q)
				MODE_NORMAL: begin
					if (item_s1.key_code == acc_pkg::KEY_SET)
						mode_n = MODE_SET_HOUR;
					else if (item_s1.key_code == acc_pkg::KEY_ALM)
						mode_n = MODE_ALARM_HOUR;
				end
				MODE_SET_HOUR: begin
					if (item_s1.key_code == acc_pkg::KEY_SET)
						mode_n = MODE_SET_MINUTE;
					else
						hours_n = 5'(step_value({1'b0, hours_q}, item_s1.key_code,
							acc_pkg::HOUR_MAX));
				end
				MODE_SET_MINUTE: begin
					if (item_s1.key_code == acc_pkg::KEY_SET) begin
						seconds_n = 6'd0;
						millis_n  = 16'd0;
						mode_n    = MODE_NORMAL;
					end else if (item_s1.key_code == acc_pkg::KEY_UP ||
							item_s1.key_code == acc_pkg::KEY_DOWN) begin
						minutes_n = step_value(minutes_q, item_s1.key_code,
							acc_pkg::MINUTE_MAX);
						seconds_n = 6'd0;
						millis_n  = 16'd0;
					end
				end
				MODE_ALARM_HOUR: begin
					if (item_s1.key_code == acc_pkg::KEY_ALM)
						mode_n = MODE_ALARM_MINUTE;
					else
						alarm_hours_n = 5'(step_value({1'b0, alarm_hours_q},
							item_s1.key_code, acc_pkg::HOUR_MAX));
				end
				MODE_ALARM_MINUTE: begin
					if (item_s1.key_code == acc_pkg::KEY_ALM) begin
						store_n = 1'b1;
						mode_n  = MODE_NORMAL;
					end else begin
						alarm_minutes_n = step_value(alarm_minutes_q, item_s1.key_code,
							acc_pkg::MINUTE_MAX);
					end
				end
				default: ;
			endcase
		end

		alarm_view = (mode_n == MODE_ALARM_HOUR || mode_n == MODE_ALARM_MINUTE);
		hidden     = !blink_phase_n;
		result_n.shown_hour     = alarm_view ? alarm_hours_n : hours_n;
		result_n.shown_minute   = alarm_view ? alarm_minutes_n : minutes_n;
		result_n.hour_visible   = !(hidden &&
			(mode_n == MODE_SET_HOUR || mode_n == MODE_ALARM_HOUR));
		result_n.minute_visible = !(hidden &&
			(mode_n == MODE_SET_MINUTE || mode_n == MODE_ALARM_MINUTE));
		result_n.led_lit            = alarm_view && blink_phase_n;
		result_n.buzzer_drive       = buzzer_n;
		result_n.mode               = mode_n;
		result_n.store_alarm        = store_n;
		result_n.alarm_hour_value   = alarm_hours_n;
		result_n.alarm_minute_value = alarm_minutes_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q  <= acc_pkg::RST_TICKS_PER_SECOND;
			blink_half_period_q <= acc_pkg::RST_BLINK_HALF_PERIOD;
			idle_timeout_q      <= acc_pkg::RST_IDLE_TIMEOUT;
			pip_length_q        <= acc_pkg::RST_PIP_LENGTH;
			alarm_half_period_q <= acc_pkg::RST_ALARM_HALF_PERIOD;
			alarm_duration_q    <= acc_pkg::RST_ALARM_DURATION;
			valid_s1        <= 1'b0;
			result_valid_q  <= 1'b0;
			mode_q          <= MODE_NORMAL;
			hours_q         <= '0;
			minutes_q       <= '0;
			seconds_q       <= '0;
			alarm_hours_q   <= '0;
			alarm_minutes_q <= '0;
			millis_q        <= '0;
			blink_cnt_q     <= '0;
			idle_cnt_q      <= '0;
			blink_phase_q   <= 1'b1;
			pip_left_q      <= '0;
			alarm_on_q      <= 1'b0;
			alarm_left_q    <= '0;
			phase_left_q    <= '0;
			phase_snd_q     <= 1'b0;
			buzzer_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					acc_pkg::REG_TICKS_PER_SECOND:  ticks_per_second_q  <= cfg_data;
					acc_pkg::REG_BLINK_HALF_PERIOD: blink_half_period_q <= cfg_data;
					acc_pkg::REG_IDLE_TIMEOUT:      idle_timeout_q      <= cfg_data;
					acc_pkg::REG_PIP_LENGTH:        pip_length_q        <= cfg_data;
					acc_pkg::REG_ALARM_HALF_PERIOD: alarm_half_period_q <= cfg_data;
					acc_pkg::REG_ALARM_DURATION:    alarm_duration_q    <= cfg_data;
					default: ;
				endcase
			end
			if (!item_stall)
				valid_s1 <= item_valid;
			if (out_free)
				result_valid_q <= valid_s1;
			if (advance) begin
				mode_q          <= mode_n;
				hours_q         <= hours_n;
				minutes_q       <= minutes_n;
				seconds_q       <= seconds_n;
				alarm_hours_q   <= alarm_hours_n;
				alarm_minutes_q <= alarm_minutes_n;
				millis_q        <= millis_n;
				blink_cnt_q     <= blink_cnt_n;
				idle_cnt_q      <= idle_cnt_n;
				blink_phase_q   <= blink_phase_n;
				pip_left_q      <= pip_left_n;
				alarm_on_q      <= alarm_on_n;
				alarm_left_q    <= alarm_left_n;
				phase_left_q    <= phase_left_n;
				phase_snd_q     <= phase_snd_n;
				buzzer_q        <= buzzer_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall)
			item_s1 <= item;
		if (advance)
			result_q <= result_n;
	end

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_time_range, clk, arst_n,
		hours_q < 5'd24 && minutes_q < 6'd60 && seconds_q < 6'd60,
		"clock time out of range")
	`ASSERT_IMPLY(a_store_leaves_edit, clk, arst_n,
		result_valid_q && result_q.store_alarm, result_q.mode == 3'(MODE_NORMAL),
		"store pulse outside normal mode")
	`ASSERT_IMPLY(a_alarm_no_pip, clk, arst_n, alarm_on_q, pip_left_q == 16'd0,
		"pip pending while alarm sounds")
	`ASSERT_IMPLY(a_stall_full, clk, arst_n, item_stall, valid_s1 && result_valid_q,
		"input stalled with a free slot")

endmodule
